### hdl/exclusive_time_accounting_macros.svh
// assertion helpers for the exclusive time accounting block
`ifndef EXCLUSIVE_TIME_ACCOUNTING_MACROS_SVH
`define EXCLUSIVE_TIME_ACCOUNTING_MACROS_SVH

// same-cycle implication, disabled during reset
`define ETA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("eta assertion failed");

// next-cycle implication, disabled during reset
`define ETA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("eta assertion failed");

`endif

### hdl/eta_pkg.sv
package eta_pkg;

    localparam int MaxFuncs   = 64;
    localparam int StackDepth = 64;
    localparam int IdW        = 6;
    localparam int TimeW      = 32;
    localparam int TotW       = 32;
    localparam int CntW       = 7;
    localparam int LvlW       = $clog2(StackDepth + 1);
    localparam int StkAw      = $clog2(StackDepth);
    localparam int FuncAw     = $clog2(MaxFuncs);

    localparam logic [CntW-1:0] FcReset = CntW'(64);

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_RANGE    = 3'd3,
        ST_BACKWARD = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TOTRD,
        S_FIN
    } t_state;

endpackage

### hdl/eta_evt_if.sv
interface eta_evt_if;
    import eta_pkg::*;

    logic             valid;
    logic             ready;
    logic [IdW-1:0]   func_id;
    logic             is_entry;
    logic [TimeW-1:0] event_time;

    modport source (output valid, output func_id, output is_entry, output event_time,
                    input ready);
    modport sink   (input valid, input func_id, input is_entry, input event_time,
                    output ready);
endinterface

### hdl/eta_res_if.sv
interface eta_res_if;
    import eta_pkg::*;

    logic            valid;
    logic            ready;
    logic            charged;
    logic [IdW-1:0]  charged_id;
    logic [TotW-1:0] charged_total;
    t_status         status;

    modport source (output valid, output charged, output charged_id, output charged_total,
                    output status, input ready);
    modport sink   (input valid, input charged, input charged_id, input charged_total,
                    input status, output ready);
endinterface

### hdl/exclusive_time_accounting.sv
// channel   | direction | word
// i_evt     | in        | func_id, is_entry, event_time
// o_res     | out       | charged, charged_id, charged_total, status
// i_cfg_*   | in        | function_count, write only
//
// one event at a time: an event that charges a total goes through stack read, totals
// read, then add and write back; an error or an entry on an empty stack skips the
// totals read; the next event is taken once the result is in the output register
// synchronous active-low reset; totals read as zero until first written (valid bits)
// a result waiting in the output register holds the finish step; the next event
// is taken while that result waits to be collected

`include "exclusive_time_accounting_macros.svh"

module exclusive_time_accounting (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [eta_pkg::CntW-1:0]  i_cfg_wdata,
    eta_evt_if.sink                   i_evt,
    eta_res_if.source                 o_res
);
    import eta_pkg::*;

    t_state              r_state, n_state;
    logic [CntW-1:0]     r_fcount;
    logic [LvlW-1:0]     r_level;
    logic [TimeW:0]      r_boundary;

    logic [IdW-1:0]      r_id;
    logic                r_entry;
    logic [TimeW-1:0]    r_time;
    t_status             r_status;
    logic                r_charge;
    logic [TimeW:0]      r_amount;

    logic [IdW-1:0]      stk_mem [StackDepth];
    logic [TotW-1:0]     tot_mem [MaxFuncs];
    logic [MaxFuncs-1:0] r_tot_vld;
    logic [IdW-1:0]      r_stk_rd;
    logic [TotW-1:0]     r_tot_rd;
    logic                r_tot_rd_vld;

    logic                r_out_valid;
    logic                r_out_charged;
    logic [IdW-1:0]      r_out_id;
    logic [TotW-1:0]     r_out_total;
    t_status             r_out_status;

    logic                in_acc;
    t_status             chk;
    logic                will_charge;
    logic [TimeW:0]      amount;
    logic [LvlW-1:0]     lvl_m1;
    logic                stk_rd_en;
    logic                tot_rd_en;
    logic                fin_go;
    logic                wr_tot;
    logic                wr_stk;
    logic [TotW-1:0]     old_total;
    logic [TotW+1:0]     sum;
    logic [TotW-1:0]     new_total;

    assign i_evt.ready = (r_state == S_IDLE);
    assign in_acc      = i_evt.valid && i_evt.ready;
    assign lvl_m1      = r_level - LvlW'(1);

    // error checks, first failing one wins
    always_comb begin
        chk = ST_OK;
        priority if (!i_evt.is_entry && r_level == '0) begin
            chk = ST_EMPTY;
        end else if (i_evt.is_entry && r_level >= LvlW'(StackDepth)) begin
            chk = ST_FULL;
        end else if ({1'b0, i_evt.func_id} >= r_fcount) begin
            chk = ST_RANGE;
        end else if ({1'b0, i_evt.event_time} < r_boundary) begin
            chk = ST_BACKWARD;
        end else begin
            chk = ST_OK;
        end
    end

    assign will_charge = (chk == ST_OK) && (!i_evt.is_entry || r_level != '0);
    assign amount      = {1'b0, i_evt.event_time} - r_boundary
                         + {{TimeW{1'b0}}, !i_evt.is_entry};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = will_charge ? S_TOTRD : S_FIN;
                end
            end
            S_TOTRD: n_state = S_FIN;
            S_FIN: begin
                if (fin_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        stk_rd_en = in_acc;
        tot_rd_en = (r_state == S_TOTRD);
        fin_go    = (r_state == S_FIN) && (!r_out_valid || o_res.ready);
        wr_tot    = fin_go && r_charge;
        wr_stk    = fin_go && (r_status == ST_OK) && r_entry;
    end

    // saturating add of the charged time
    assign old_total = r_tot_rd_vld ? r_tot_rd : '0;
    assign sum       = {2'b00, old_total} + {1'b0, r_amount};
    assign new_total = (sum[TotW+1:TotW] != 2'b00) ? '1 : sum[TotW-1:0];

    // call stack memory
    always_ff @(posedge i_clk) begin
        if (stk_rd_en) begin
            r_stk_rd <= stk_mem[lvl_m1[StkAw-1:0]];
        end
        if (wr_stk) begin
            stk_mem[r_level[StkAw-1:0]] <= r_id;
        end
    end

    // totals memory
    always_ff @(posedge i_clk) begin
        if (tot_rd_en) begin
            r_tot_rd <= tot_mem[r_stk_rd[FuncAw-1:0]];
        end
        if (wr_tot) begin
            tot_mem[r_stk_rd[FuncAw-1:0]] <= new_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tot_vld    <= '0;
            r_tot_rd_vld <= 1'b0;
        end else begin
            if (tot_rd_en) begin
                r_tot_rd_vld <= r_tot_vld[r_stk_rd[FuncAw-1:0]];
            end
            if (wr_tot) begin
                r_tot_vld[r_stk_rd[FuncAw-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fcount    <= FcReset;
            r_level     <= '0;
            r_boundary  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_fcount <= i_cfg_wdata;
            end
            if (fin_go && r_status == ST_OK) begin
                if (r_entry) begin
                    r_level    <= r_level + LvlW'(1);
                    r_boundary <= {1'b0, r_time};
                end else begin
                    r_level    <= r_level - LvlW'(1);
                    r_boundary <= {1'b0, r_time} + (TimeW+1)'(1);
                end
            end
            if (fin_go) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_id     <= i_evt.func_id;
            r_entry  <= i_evt.is_entry;
            r_time   <= i_evt.event_time;
            r_status <= chk;
            r_charge <= will_charge;
            r_amount <= amount;
        end
        if (fin_go) begin
            r_out_charged <= r_charge;
            r_out_id      <= r_charge ? r_stk_rd : '0;
            r_out_total   <= r_charge ? new_total : '0;
            r_out_status  <= r_status;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.charged       = r_out_charged;
    assign o_res.charged_id    = r_out_id;
    assign o_res.charged_total = r_out_total;
    assign o_res.status        = r_out_status;

    `ETA_ASSERT_NOW(a_res_from_fin, $rose(r_out_valid), $past(r_state) == S_FIN)
    `ETA_ASSERT_NEXT(a_push_level, fin_go && r_status == ST_OK && r_entry, r_level == $past(r_level) + LvlW'(1))
    `ETA_ASSERT_NEXT(a_pop_level, fin_go && r_status == ST_OK && !r_entry, r_level == $past(r_level) - LvlW'(1))
    `ETA_ASSERT_NOW(a_err_no_charge, r_out_valid && r_out_status != ST_OK, !r_out_charged && r_out_total == '0)

endmodule

### bench/exclusive_time_accounting_tb.sv
`timescale 1ns / 100ps

module exclusive_time_accounting_tb;
    import eta_pkg::*;

    localparam int StallLimit = 2000;

    typedef struct packed {
        logic [IdW-1:0]   fid;
        logic             entry;
        logic [TimeW-1:0] ts;
    } t_trace_evt;

    typedef struct packed {
        logic            charged;
        logic [IdW-1:0]  id;
        logic [TotW-1:0] total;
        t_status         status;
    } t_tally;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CntW-1:0]  i_cfg_wdata;

    eta_evt_if evt_bus ();
    eta_res_if res_bus ();

    exclusive_time_accounting i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_evt       (evt_bus),
        .o_res       (res_bus)
    );

    // predicted state of the block
    logic [CntW-1:0]  live_fcount;
    logic [IdW-1:0]   frame_ids [StackDepth];
    int               frame_level;
    logic [TotW-1:0]  fn_totals [MaxFuncs];
    logic [TimeW:0]   charge_from;

    // stimulus side view of the stack
    int unsigned      gen_level;
    logic [TimeW:0]   gen_bound;
    int unsigned      gen_fcount;
    int unsigned      entry_bias;

    t_trace_evt       pending_events [$];
    t_tally           owed_tallies [$];
    int               mismatch_count;
    int               quiet_cycles;
    int unsigned      cycle_count;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_tally account_event(t_trace_evt ev);
        t_tally          got;
        logic [TimeW:0]  stamp;
        logic [TimeW:0]  span;
        logic [TotW+1:0] sum;
        logic [IdW-1:0]  top;
        got = '0;
        stamp = {1'b0, ev.ts};
        if (!ev.entry && frame_level == 0) begin
            got.status = ST_EMPTY;
        end else if (ev.entry && frame_level >= StackDepth) begin
            got.status = ST_FULL;
        end else if (ev.fid >= live_fcount) begin
            got.status = ST_RANGE;
        end else if (stamp < charge_from) begin
            got.status = ST_BACKWARD;
        end else begin
            got.status = ST_OK;
            if (frame_level > 0) begin
                top = frame_ids[frame_level - 1];
                span = ev.entry ? stamp - charge_from : stamp - charge_from + 1;
                sum = fn_totals[top] + span;
                fn_totals[top] = (sum > {TotW{1'b1}}) ? '1 : TotW'(sum);
                got.charged = 1'b1;
                got.id = top;
                got.total = fn_totals[top];
            end
            if (ev.entry) begin
                frame_ids[frame_level] = ev.fid;
                frame_level++;
                charge_from = stamp;
            end else begin
                frame_level--;
                charge_from = stamp + 1;
            end
        end
        return got;
    endfunction

    function automatic void flag_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void check_tally(t_tally want);
        flag_field("charged", 32'(want.charged), 32'(res_bus.charged));
        flag_field("charged_id", 32'(want.id), 32'(res_bus.charged_id));
        flag_field("charged_total", want.total, res_bus.charged_total);
        flag_field("status", 32'(want.status), 32'(res_bus.status));
    endfunction

    function automatic bit take_break();
        return (cycle_count % 2500) < 1700 && $urandom_range(99) < 26;
    endfunction

    task automatic queue_event(logic [IdW-1:0] id, logic entry, logic [TimeW-1:0] ts,
                               bit ok);
        pending_events = {pending_events, t_trace_evt'({id, entry, ts})};
        if (ok) begin
            if (entry) begin
                gen_level++;
                gen_bound = {1'b0, ts};
            end else begin
                gen_level--;
                gen_bound = {1'b0, ts} + 1;
            end
        end
    endtask

    task automatic queue_clean_event();
        logic           entry;
        logic [TimeW:0] step;
        int unsigned    pick;
        entry = gen_level == 0 ||
                (gen_level < StackDepth && $urandom_range(99) < entry_bias);
        pick = $urandom_range(99);
        step = (pick < 70) ? $urandom_range(3) :
               (pick < 95) ? $urandom_range(100) : $urandom_range(65535);
        queue_event(IdW'($urandom_range(gen_fcount - 1)), entry,
                    TimeW'(gen_bound + step), 1'b1);
    endtask

    task automatic queue_broken_event();
        int unsigned kind;
        kind = $urandom_range(3);
        if (kind == 0 && gen_level == 0) begin
            queue_event(IdW'($urandom), 1'b0, $urandom, 1'b0);
        end else if (kind == 1 && gen_level == StackDepth) begin
            queue_event(IdW'($urandom), 1'b1, $urandom, 1'b0);
        end else if (gen_fcount < MaxFuncs && (kind == 2 || gen_fcount == 0)) begin
            queue_event(IdW'($urandom_range(MaxFuncs - 1, gen_fcount)), 1'($urandom),
                        $urandom, 1'b0);
        end else if (gen_bound != 0) begin
            queue_event(IdW'($urandom), 1'($urandom),
                        $urandom_range(32'(gen_bound - 1)), 1'b0);
        end else begin
            queue_clean_event();
        end
    endtask

    task automatic drain();
        while (pending_events.size() != 0 || owed_tallies.size() != 0 || evt_bus.valid)
            @(negedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!evt_bus.valid || evt_bus.ready) begin
            if (i_rst_n && pending_events.size() != 0 && !take_break()) begin
                evt_bus.valid      <= 1'b1;
                evt_bus.func_id    <= pending_events[0].fid;
                evt_bus.is_entry   <= pending_events[0].entry;
                evt_bus.event_time <= pending_events[0].ts;
                void'(pending_events.pop_front());
            end else begin
                evt_bus.valid <= 1'b0;
            end
        end
    end

    // monitor and predictor
    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (owed_tallies.size() == 0) begin
                $display("%0t: no word expected, actual charged %0d id %0d total %0d status %0d",
                         $time, res_bus.charged, res_bus.charged_id, res_bus.charged_total,
                         res_bus.status);
                mismatch_count++;
            end else begin
                check_tally(owed_tallies.pop_front());
            end
        end
        if (i_rst_n && evt_bus.valid && evt_bus.ready)
            owed_tallies = {owed_tallies, account_event({evt_bus.func_id, evt_bus.is_entry,
                                                         evt_bus.event_time})};
        if (i_cfg_we)
            live_fcount = i_cfg_wdata;
        res_bus.ready <= !take_break();
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if ((evt_bus.valid && evt_bus.ready) || (res_bus.valid && res_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < StallLimit) @(posedge i_clk);
        $display("tb: failure");
        $finish;
    end

    initial begin
        int unsigned fc_plan [6];
        int unsigned item_plan [6];
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        evt_bus.valid = 1'b0;
        evt_bus.func_id = '0;
        evt_bus.is_entry = 1'b0;
        evt_bus.event_time = '0;
        res_bus.ready = 1'b0;
        live_fcount = FcReset;
        frame_level = 0;
        charge_from = '0;
        foreach (frame_ids[k]) frame_ids[k] = '0;
        foreach (fn_totals[k]) fn_totals[k] = '0;
        gen_level = 0;
        gen_bound = '0;
        gen_fcount = MaxFuncs;
        entry_bias = 50;
        mismatch_count = 0;
        quiet_cycles = 0;
        cycle_count = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // short directed run at the reset function count
        queue_event(0, 1'b0, 0, 1'b0);
        queue_event(63, 1'b0, '1, 1'b0);
        queue_event(0, 1'b1, 0, 1'b1);
        queue_event(63, 1'b1, 7, 1'b1);
        queue_event(21, 1'b1, 7, 1'b1);
        queue_event(42, 1'b1, 3, 1'b0);
        queue_event(42, 1'b0, 12, 1'b1);
        queue_event(0, 1'b0, 12, 1'b0);
        queue_event(0, 1'b0, 13, 1'b1);
        queue_event(5, 1'b1, 20, 1'b1);
        queue_event(5, 1'b0, 20, 1'b1);
        queue_event(0, 1'b0, 30, 1'b1);
        queue_event(0, 1'b0, 40, 1'b0);

        fc_plan = '{64, 1, 0, 0, 64, 0};
        fc_plan[2] = $urandom_range(63, 2);
        fc_plan[5] = $urandom_range(64, 1);
        item_plan = '{270, 130, 230, 20, 300, 180};
        for (int p = 0; p < 6; p++) begin
            drain();
            @(posedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_wdata <= CntW'(fc_plan[p]);
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
            gen_fcount = fc_plan[p];
            @(negedge i_clk);
            if (gen_fcount == MaxFuncs) begin
                // fill the stack then push once more
                entry_bias = 100;
                while (gen_level < StackDepth) queue_clean_event();
                queue_event(IdW'($urandom), 1'b1, $urandom, 1'b0);
            end
            for (int n = 0; n < item_plan[p]; n++) begin
                if (n % 150 == 0)
                    entry_bias = $urandom_range(1) ? 75 : 30;
                if (gen_fcount != 0 && $urandom_range(99) < 80)
                    queue_clean_event();
                else
                    queue_broken_event();
            end
        end

        // run the time up to its top value, then past it
        while (gen_level > StackDepth - 2) queue_event(0, 1'b0, TimeW'(gen_bound), 1'b1);
        queue_event(0, 1'b1, TimeW'(gen_bound), 1'b1);
        queue_event(0, 1'b1, '1, 1'b1);
        queue_event(0, 1'b0, '1, 1'b1);
        queue_event(0, 1'b0, '1, 1'b0);
        queue_event(0, 1'b1, '1, 1'b0);

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && owed_tallies.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
